@@ hw/rtl/triangle_unit_normal_and_area_assert.svh @@
// Assertion macros for the triangle normal and area block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef TRIANGLE_UNIT_NORMAL_AND_AREA_ASSERT_SVH
`define TRIANGLE_UNIT_NORMAL_AND_AREA_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define TNORM_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Invariant checked at every clock edge outside reset.
`define TNORM_ASSERT_ALWAYS(label, cons, msg) \
    `TNORM_ASSERT_IMPL(label, 1'b1, cons, msg)

`endif

@@ hw/rtl/tnorm_pkg.sv @@
// Shared widths, types and constants for the triangle normal and area block.
// No dependencies.
`default_nettype none

package tnorm_pkg;

    localparam int COORD_WIDTH = 20;
    localparam int AXES        = 3;
    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int HALF_W      = PROD_W / 2;
    localparam int SQ_W        = 2 * PROD_W;
    localparam int SUM_W       = SQ_W + 2;
    localparam int REM_W       = SUM_W + 1;
    localparam int NORM_W      = 16;
    localparam int AREA_W      = 42;
    localparam int NORM_ONE    = 16384;
    // quotient of |c|^2 * 2^30 / |C|^2, then its root
    localparam int NORM_SHIFT  = 30;
    localparam int QUO_W       = NORM_SHIFT + 1;
    localparam int NROOT_W     = (QUO_W + 1) / 2;
    localparam int AROOT_W     = (SUM_W + 1) / 2;
    localparam int BACK_DEPTH  = (QUO_W + NROOT_W > AROOT_W) ? (QUO_W + NROOT_W) : AROOT_W;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [NORM_W-1:0]      norm_t;
    typedef logic [AREA_W-1:0]             area_t;

    typedef struct packed {
        coord_t first_x;
        coord_t first_y;
        coord_t first_z;
        coord_t second_x;
        coord_t second_y;
        coord_t second_z;
        coord_t third_x;
        coord_t third_y;
        coord_t third_z;
    } corners_t;

    typedef struct packed {
        logic [AXES-1:0][SQ_W-1:0] sq;
        logic [SUM_W-1:0]          sum;
        logic [AXES-1:0]           neg;
    } cross_sum_t;

endpackage

`default_nettype wire

@@ hw/rtl/tnorm_if.sv @@
// Valid/ready channel interfaces for the triangle normal and area block.
// Depends on tnorm_pkg.
`default_nettype none

interface tnorm_corners_if;
    logic              valid;
    logic              ready;
    tnorm_pkg::coord_t first_x;
    tnorm_pkg::coord_t first_y;
    tnorm_pkg::coord_t first_z;
    tnorm_pkg::coord_t second_x;
    tnorm_pkg::coord_t second_y;
    tnorm_pkg::coord_t second_z;
    tnorm_pkg::coord_t third_x;
    tnorm_pkg::coord_t third_y;
    tnorm_pkg::coord_t third_z;

    modport source (output valid, first_x, first_y, first_z, second_x, second_y, second_z,
                    third_x, third_y, third_z, input ready);
    modport sink (input valid, first_x, first_y, first_z, second_x, second_y, second_z,
                  third_x, third_y, third_z, output ready);
endinterface

interface tnorm_result_if;
    logic             valid;
    logic             ready;
    tnorm_pkg::norm_t normal_x;
    tnorm_pkg::norm_t normal_y;
    tnorm_pkg::norm_t normal_z;
    tnorm_pkg::area_t area;
    logic             degenerate;

    modport source (output valid, normal_x, normal_y, normal_z, area, degenerate,
                    input ready);
    modport sink (input valid, normal_x, normal_y, normal_z, area, degenerate,
                  output ready);
endinterface

`default_nettype wire

@@ hw/rtl/tnorm_cross.sv @@
// Front pipeline: edge vectors, cross product, squared components and their sum.
// Six register stages; depends on tnorm_pkg.
`default_nettype none

module tnorm_cross (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  tnorm_pkg::corners_t   corners,
    output logic                  out_valid,
    output tnorm_pkg::cross_sum_t sums
);

    localparam int DW    = tnorm_pkg::DIFF_W;
    localparam int PW    = tnorm_pkg::PROD_W;
    localparam int HW    = tnorm_pkg::HALF_W;
    localparam int SQW   = tnorm_pkg::SQ_W;
    localparam int SW    = tnorm_pkg::SUM_W;
    localparam int AX    = tnorm_pkg::AXES;
    localparam int DEPTH = 6;

    logic [DEPTH-1:0] valid_reg;

    logic signed [DW-1:0] e1_reg [AX];
    logic signed [DW-1:0] e2_reg [AX];
    logic signed [DW-1:0] e1_next [AX];
    logic signed [DW-1:0] e2_next [AX];
    logic signed [PW-1:0] prod_reg [2*AX];
    logic signed [PW-1:0] prod_next [2*AX];
    logic [PW-1:0]        mag_reg [AX];
    logic [PW-1:0]        mag_next [AX];
    logic [AX-1:0]        neg3_reg, neg4_reg, neg5_reg, neg6_reg;
    logic [AX-1:0]        neg_next;
    logic [PW-1:0]        hh_reg [AX];
    logic [PW-1:0]        hl_reg [AX];
    logic [PW-1:0]        ll_reg [AX];
    logic [PW-1:0]        hh_next [AX];
    logic [PW-1:0]        hl_next [AX];
    logic [PW-1:0]        ll_next [AX];
    logic [SQW-1:0]       sq_reg [AX];
    logic [SQW-1:0]       sq_next [AX];
    logic [SQW-1:0]       sq6_reg [AX];
    logic [SW-1:0]        sum_reg;
    logic [SW-1:0]        sum_next;

    always_comb
    begin
        e1_next[0] = DW'(corners.second_x) - DW'(corners.first_x);
        e1_next[1] = DW'(corners.second_y) - DW'(corners.first_y);
        e1_next[2] = DW'(corners.second_z) - DW'(corners.first_z);
        e2_next[0] = DW'(corners.third_x) - DW'(corners.first_x);
        e2_next[1] = DW'(corners.third_y) - DW'(corners.first_y);
        e2_next[2] = DW'(corners.third_z) - DW'(corners.first_z);
    end

    // cross product terms, minuend then subtrahend per axis
    always_comb
    begin
        prod_next[0] = PW'(e1_reg[1]) * PW'(e2_reg[2]);
        prod_next[1] = PW'(e1_reg[2]) * PW'(e2_reg[1]);
        prod_next[2] = PW'(e1_reg[2]) * PW'(e2_reg[0]);
        prod_next[3] = PW'(e1_reg[0]) * PW'(e2_reg[2]);
        prod_next[4] = PW'(e1_reg[0]) * PW'(e2_reg[1]);
        prod_next[5] = PW'(e1_reg[1]) * PW'(e2_reg[0]);
    end

    always_comb
    begin
        logic signed [PW:0] diff;
        diff = '0;
        for (int i = 0; i < AX; i++)
        begin
            diff        = (PW+1)'(prod_reg[2*i]) - (PW+1)'(prod_reg[2*i+1]);
            neg_next[i] = diff[PW];
            mag_next[i] = diff[PW] ? PW'(-diff) : PW'(diff);
        end
    end

    // square each magnitude from three half-width partial products
    always_comb
    begin
        for (int i = 0; i < AX; i++)
        begin
            hh_next[i] = PW'(mag_reg[i][PW-1:HW]) * PW'(mag_reg[i][PW-1:HW]);
            hl_next[i] = PW'(mag_reg[i][PW-1:HW]) * PW'(mag_reg[i][HW-1:0]);
            ll_next[i] = PW'(mag_reg[i][HW-1:0]) * PW'(mag_reg[i][HW-1:0]);
            sq_next[i] = (SQW'(hh_reg[i]) << PW) + (SQW'(hl_reg[i]) << (HW + 1))
                       + SQW'(ll_reg[i]);
        end
        sum_next = SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[DEPTH-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < AX; i++)
            begin
                e1_reg[i]  <= e1_next[i];
                e2_reg[i]  <= e2_next[i];
                mag_reg[i] <= mag_next[i];
                hh_reg[i]  <= hh_next[i];
                hl_reg[i]  <= hl_next[i];
                ll_reg[i]  <= ll_next[i];
                sq_reg[i]  <= sq_next[i];
                sq6_reg[i] <= sq_reg[i];
            end
            for (int i = 0; i < 2*AX; i++)
            begin
                prod_reg[i] <= prod_next[i];
            end
            neg3_reg <= neg_next;
            neg4_reg <= neg3_reg;
            neg5_reg <= neg4_reg;
            neg6_reg <= neg5_reg;
            sum_reg  <= sum_next;
        end
    end

    always_comb
    begin
        for (int i = 0; i < AX; i++)
        begin
            sums.sq[i] = sq6_reg[i];
        end
        sums.sum = sum_reg;
        sums.neg = neg6_reg;
    end

    assign out_valid = valid_reg[DEPTH-1];

endmodule

`default_nettype wire

@@ hw/rtl/tnorm_normal.sv @@
// Normal pipeline: per axis restoring division |c|^2 * 2^30 / |C|^2, one quotient bit
// a stage, then an integer root one bit a stage, then round, clamp and sign. Depends on tnorm_pkg.
`default_nettype none

module tnorm_normal (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         en,
    input  logic                                         in_valid,
    input  tnorm_pkg::cross_sum_t                        sums,
    output logic                                         out_valid,
    output logic [tnorm_pkg::AXES-1:0][tnorm_pkg::NORM_W-1:0] normal
);

    localparam int AX  = tnorm_pkg::AXES;
    localparam int BD  = tnorm_pkg::BACK_DEPTH;
    localparam int QW  = tnorm_pkg::QUO_W;
    localparam int RTW = tnorm_pkg::NROOT_W;
    localparam int RW  = tnorm_pkg::REM_W;
    localparam int SW  = tnorm_pkg::SUM_W;
    localparam int NW  = tnorm_pkg::NORM_W;
    localparam int TW  = RW + 1;

    typedef struct packed {
        logic [RW-1:0]  rem;
        logic [QW-1:0]  quo;
        logic [RTW-1:0] root;
    } nlane_t;

    function automatic nlane_t div_step(input nlane_t a, input logic [SW-1:0] s,
                                        input logic last);
        nlane_t        r;
        logic          take;
        logic [RW-1:0] red;
        take   = a.rem >= RW'(s);
        red    = take ? a.rem - RW'(s) : a.rem;
        r.quo  = {a.quo[QW-2:0], take};
        r.root = a.root;
        // after the last quotient bit the quotient itself becomes the root operand
        r.rem  = last ? RW'(r.quo) : red << 1;
        return r;
    endfunction

    function automatic nlane_t root_step(input nlane_t a, input int b);
        nlane_t        r;
        logic          take;
        logic [TW-1:0] trial;
        r     = a;
        trial = (TW'(a.root) << (b + 1)) + (TW'(1) << (2 * b));
        take  = TW'(a.rem) >= trial;
        if (take)
        begin
            r.rem  = RW'(TW'(a.rem) - trial);
            r.root = a.root | (RTW'(1) << b);
        end
        return r;
    endfunction

    logic [BD-1:0]  valid_reg;
    logic [SW-1:0]  sum_reg [BD];
    logic [AX-1:0]  neg_reg [BD];
    logic           zero_reg [BD];
    nlane_t         lane_reg [BD][AX];
    nlane_t         lane_in [BD][AX];
    nlane_t         lane_next [BD][AX];
    logic [SW-1:0]  sum_in [BD];
    logic           out_valid_reg;
    logic [NW-1:0]  normal_reg [AX];
    logic [NW-1:0]  normal_next [AX];

    for (genvar st = 0; st < BD; st++)
    begin : g_stage
        if (st == 0)
        begin : g_first
            assign sum_in[st] = sums.sum;
        end
        else
        begin : g_rest
            assign sum_in[st] = sum_reg[st-1];
        end
        for (genvar l = 0; l < AX; l++)
        begin : g_lane
            if (st == 0)
            begin : g_load
                assign lane_in[st][l] = '{rem: RW'(sums.sq[l]), quo: '0, root: '0};
            end
            else
            begin : g_chain
                assign lane_in[st][l] = lane_reg[st-1][l];
            end
            if (st < QW)
            begin : g_div
                assign lane_next[st][l] = div_step(lane_in[st][l], sum_in[st], st == QW - 1);
            end
            else if (st < QW + RTW)
            begin : g_root
                assign lane_next[st][l] = root_step(lane_in[st][l], RTW - 1 - (st - QW));
            end
            else
            begin : g_hold
                assign lane_next[st][l] = lane_in[st][l];
            end
        end
    end

    // round half up on the root, clamp at one, then apply the sign; zero if |C|^2 is zero
    always_comb
    begin
        logic [RTW:0]  qr;
        logic [NW-1:0] mag;
        qr  = '0;
        mag = '0;
        for (int l = 0; l < AX; l++)
        begin
            qr = ((RTW+1)'(lane_reg[BD-1][l].root) + (RTW+1)'(1)) >> 1;
            if (qr > (RTW+1)'(tnorm_pkg::NORM_ONE))
            begin
                qr = (RTW+1)'(tnorm_pkg::NORM_ONE);
            end
            mag = NW'(qr);
            if (zero_reg[BD-1])
            begin
                normal_next[l] = '0;
            end
            else if (neg_reg[BD-1][l])
            begin
                normal_next[l] = -mag;
            end
            else
            begin
                normal_next[l] = mag;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg     <= {valid_reg[BD-2:0], in_valid};
            out_valid_reg <= valid_reg[BD-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg[0]  <= sums.sum;
            neg_reg[0]  <= sums.neg;
            zero_reg[0] <= (sums.sum == '0);
            for (int st = 1; st < BD; st++)
            begin
                sum_reg[st]  <= sum_reg[st-1];
                neg_reg[st]  <= neg_reg[st-1];
                zero_reg[st] <= zero_reg[st-1];
            end
            for (int st = 0; st < BD; st++)
            begin
                for (int l = 0; l < AX; l++)
                begin
                    lane_reg[st][l] <= lane_next[st][l];
                end
            end
            for (int l = 0; l < AX; l++)
            begin
                normal_reg[l] <= normal_next[l];
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < AX; l++)
        begin
            normal[l] = normal_reg[l];
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

@@ hw/rtl/tnorm_area.sv @@
// Area pipeline: integer root of |C|^2 one bit a stage, padded to the normal
// pipeline's depth, then halve with rounding and saturate. Depends on tnorm_pkg.
`default_nettype none

module tnorm_area (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  tnorm_pkg::cross_sum_t sums,
    output logic                  out_valid,
    output tnorm_pkg::area_t      area,
    output logic                  degenerate
);

    localparam int BD  = tnorm_pkg::BACK_DEPTH;
    localparam int RTW = tnorm_pkg::AROOT_W;
    localparam int SW  = tnorm_pkg::SUM_W;
    localparam int AW  = tnorm_pkg::AREA_W;
    localparam int TW  = SW + 2;

    typedef struct packed {
        logic [SW-1:0]  rem;
        logic [RTW-1:0] root;
    } alane_t;

    function automatic alane_t root_step(input alane_t a, input int b);
        alane_t        r;
        logic          take;
        logic [TW-1:0] trial;
        r     = a;
        trial = (TW'(a.root) << (b + 1)) + (TW'(1) << (2 * b));
        take  = TW'(a.rem) >= trial;
        if (take)
        begin
            r.rem  = SW'(TW'(a.rem) - trial);
            r.root = a.root | (RTW'(1) << b);
        end
        return r;
    endfunction

    logic [BD-1:0] valid_reg;
    logic          zero_reg [BD];
    alane_t        lane_reg [BD];
    alane_t        lane_in [BD];
    alane_t        lane_next [BD];
    logic          out_valid_reg;
    logic [AW-1:0] area_reg;
    logic [AW-1:0] area_next;
    logic          degenerate_reg;

    for (genvar st = 0; st < BD; st++)
    begin : g_stage
        if (st == 0)
        begin : g_load
            assign lane_in[st] = '{rem: sums.sum, root: '0};
        end
        else
        begin : g_chain
            assign lane_in[st] = lane_reg[st-1];
        end
        if (st < RTW)
        begin : g_root
            assign lane_next[st] = root_step(lane_in[st], RTW - 1 - st);
        end
        else
        begin : g_hold
            assign lane_next[st] = lane_in[st];
        end
    end

    always_comb
    begin
        logic [RTW:0] half;
        half = ((RTW+1)'(lane_reg[BD-1].root) + (RTW+1)'(1)) >> 1;
        if (zero_reg[BD-1])
        begin
            area_next = '0;
        end
        else if ((half >> AW) != '0)
        begin
            area_next = '1;
        end
        else
        begin
            area_next = AW'(half);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg     <= {valid_reg[BD-2:0], in_valid};
            out_valid_reg <= valid_reg[BD-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg[0] <= (sums.sum == '0);
            for (int st = 1; st < BD; st++)
            begin
                zero_reg[st] <= zero_reg[st-1];
            end
            for (int st = 0; st < BD; st++)
            begin
                lane_reg[st] <= lane_next[st];
            end
            area_reg       <= area_next;
            degenerate_reg <= zero_reg[BD-1];
        end
    end

    assign out_valid  = out_valid_reg;
    assign area       = area_reg;
    assign degenerate = degenerate_reg;

endmodule

`default_nettype wire

@@ hw/rtl/triangle_unit_normal_and_area.sv @@
// Top level of the triangle normal and area block: front cross-product pipeline
// feeding the normal and area pipelines. Depends on tnorm_pkg, tnorm_if and the submodules.
`default_nettype none
`include "triangle_unit_normal_and_area_assert.svh"

// Takes one triangle request per clock while the result channel is not stalled and returns
// its unit normal (Q2.14, rounded to nearest) and area (unsigned Q42.0, saturating) in order:
// 6 stages form the cross product and its squared length, 47 stages divide and take roots
// one bit per stage (31 quotient bits of the normal division followed by a 16-bit root, the
// 43-bit area root padded to match), and one output register. The whole pipeline advances
// together and holds while a finished result sits unaccepted on the result channel.
module triangle_unit_normal_and_area (
    input  logic            clk,
    input  logic            rst_n,
    tnorm_corners_if.sink   corners,
    tnorm_result_if.source  result
);

    localparam int AX = tnorm_pkg::AXES;
    localparam logic signed [tnorm_pkg::NORM_W-1:0] NORM_MAX =
        tnorm_pkg::NORM_W'(tnorm_pkg::NORM_ONE);

    logic                  advance;
    tnorm_pkg::corners_t   corner_data;
    tnorm_pkg::cross_sum_t sums;
    logic                  sums_valid;
    logic                  norm_valid;
    logic                  area_valid;
    logic [AX-1:0][tnorm_pkg::NORM_W-1:0] normal;
    tnorm_pkg::area_t      area;
    logic                  degenerate;

    // advance unless a finished result is stalled
    assign advance       = !area_valid || result.ready;
    assign corners.ready = advance;

    assign corner_data.first_x  = corners.first_x;
    assign corner_data.first_y  = corners.first_y;
    assign corner_data.first_z  = corners.first_z;
    assign corner_data.second_x = corners.second_x;
    assign corner_data.second_y = corners.second_y;
    assign corner_data.second_z = corners.second_z;
    assign corner_data.third_x  = corners.third_x;
    assign corner_data.third_y  = corners.third_y;
    assign corner_data.third_z  = corners.third_z;

    tnorm_cross u_cross (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (corners.valid),
        .corners   (corner_data),
        .out_valid (sums_valid),
        .sums      (sums)
    );

    tnorm_normal u_normal (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (sums_valid),
        .sums      (sums),
        .out_valid (norm_valid),
        .normal    (normal)
    );

    tnorm_area u_area (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (advance),
        .in_valid   (sums_valid),
        .sums       (sums),
        .out_valid  (area_valid),
        .area       (area),
        .degenerate (degenerate)
    );

    assign result.valid      = area_valid;
    assign result.normal_x   = $signed(normal[0]);
    assign result.normal_y   = $signed(normal[1]);
    assign result.normal_z   = $signed(normal[2]);
    assign result.area       = area;
    assign result.degenerate = degenerate;

    `TNORM_ASSERT_ALWAYS(a_paths_aligned, norm_valid == area_valid, "normal and area paths out of step")
    `TNORM_ASSERT_IMPL(a_degenerate_zero, result.valid && result.degenerate, (result.area == '0) && (result.normal_x == '0) && (result.normal_y == '0) && (result.normal_z == '0), "degenerate result not zero")
    `TNORM_ASSERT_IMPL(a_normal_range, result.valid, (result.normal_x <= NORM_MAX) && (result.normal_x >= -NORM_MAX) && (result.normal_y <= NORM_MAX) && (result.normal_y >= -NORM_MAX) && (result.normal_z <= NORM_MAX) && (result.normal_z >= -NORM_MAX), "normal component beyond one")
    `TNORM_ASSERT_IMPL(a_area_nonzero, result.valid && !result.degenerate, result.area != '0, "zero area on a proper triangle")

endmodule

`default_nettype wire
